// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Each macro expects the enclosing module to have ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/rgs_pkg.sv =====
package rgs_pkg;

   // Gain and ramp word widths, unsigned Q4.12 gain.
   localparam int GAIN_W     = 16;
   localparam int FADE_W     = 16;
   localparam int CHCNT_W    = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int FRAC_BITS  = 12;
   localparam int ROUND_BIAS = 2048;

   // Reset values of the control registers.
   localparam logic [GAIN_W-1:0]  GAIN_UNITY    = 16'd4096;
   localparam logic [FADE_W-1:0]  FADE_RESET    = 16'd0;
   localparam logic [CHCNT_W-1:0] CHCNT_RESET   = 4'd2;
   localparam logic               ENABLE_RESET  = 1'b1;

   // Control register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_GAIN   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FADE_FRAMES   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_COUNT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE        = 2'd3;

   // Interpolation divider: 32-bit magnitude dividend, one quotient bit per cycle.
   localparam int DIVIDEND_W = 32;
   localparam int DIV_CNT_W  = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic mul;
      logic abs_load;
      logic div;
      logic apply;
      logic scale;
      logic round;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_step;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/rgs_ctrl.sv =====
`include "assert_macros.svh"

module rgs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  rgs_pkg::stat_type stat_i,
   output rgs_pkg::cmd_type  cmd_o
);
   import rgs_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_ABS   = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_APPLY = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_ROUND = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd_o      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_o.accept = 1'b1;
               state_in     = stat_i.need_step ? ST_MUL : ST_SCALE;
            end
         end
         ST_MUL: begin
            cmd_o.mul = 1'b1;
            state_in  = ST_ABS;
         end
         ST_ABS: begin
            cmd_o.abs_load = 1'b1;
            div_cnt_in     = '0;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            cmd_o.div  = 1'b1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd_o.apply = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            cmd_o.scale = 1'b1;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            if (stat_i.out_free) begin
               cmd_o.round = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and iteration counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   `ASSERT_NEXT(a_div_ends, state_ff == ST_DIV && div_cnt_ff == DIV_LAST, state_ff == ST_APPLY, "divider did not hand over to apply")
   `ASSERT_NEXT(a_accept_route, cmd_o.accept, state_ff == ST_MUL || state_ff == ST_SCALE, "accepted transaction took a wrong path")

endmodule

// ===== sv/rgs_datapath.sv =====
`include "assert_macros.svh"

module rgs_datapath #(
   parameter  int SAMPLE_BITS  = 24,
   parameter  int MAX_CHANNELS = 8,
   localparam int DATA_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rgs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rgs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [DATA_W-1:0]                 req_tdata,
   input  logic                              req_tuser,
   input  rgs_pkg::cmd_type                  cmd_i,
   output rgs_pkg::stat_type                 stat_o,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [DATA_W-1:0]                 rsp_tdata,
   output logic                              rsp_tuser
);
   import rgs_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int CH_W = $clog2(MAX_CHANNELS + 1);
   localparam int Q_W  = SB + 6;
   localparam logic [4:0] MAX_CH5 = 5'(MAX_CHANNELS);
   localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(-(64'sd1 <<< (SB - 1)));

   // Control registers.
   logic [GAIN_W-1:0]  target_ff;
   logic [FADE_W-1:0]  fade_ff;
   logic [CHCNT_W-1:0] chcnt_ff;
   logic               enable_ff;

   // Ramp state.
   logic [GAIN_W-1:0]  cur_gain_ff, start_gain_ff, tgt_gain_ff;
   logic [FADE_W-1:0]  pos_ff, len_ff;
   logic               pending_ff;
   logic [CH_W-1:0]    idx_ff;

   // Working registers.
   logic signed [SB-1:0]       sample_ff;
   logic                       bypass_ff;
   logic signed [33:0]         prod_ff;
   logic                       neg_ff;
   logic [DIVIDEND_W-1:0]      quo_ff;
   logic [FADE_W:0]            rem_ff;
   logic signed [SB+16:0]      mul_ff;
   logic signed [SB-1:0]       out_sample_ff;
   logic                       out_ramping_ff;
   logic                       rsp_valid_ff;

   // Accept-time decode.
   logic [4:0]        ch5, eff5, idx_raw5, idx0_5, nidx_raw5, nidx5;
   logic              start, latch, active_a, step;
   logic [FADE_W-1:0] len_a, pos_a;

   always_comb begin
      ch5 = {1'b0, chcnt_ff};
      if (ch5 == 5'd0) begin
         eff5 = 5'd1;
      end else if (ch5 > MAX_CH5) begin
         eff5 = MAX_CH5;
      end else begin
         eff5 = ch5;
      end
      start     = req_tuser;
      idx_raw5  = start ? 5'd0 : 5'(idx_ff);
      idx0_5    = (idx_raw5 >= eff5) ? 5'd0 : idx_raw5;
      nidx_raw5 = idx0_5 + 5'd1;
      nidx5     = (nidx_raw5 >= eff5) ? 5'd0 : nidx_raw5;
      latch     = enable_ff & start & pending_ff;
      len_a     = latch ? fade_ff : len_ff;
      pos_a     = latch ? '0 : pos_ff;
      active_a  = (len_a != '0) && (pos_a < len_a);
      step      = enable_ff && (idx0_5 == 5'd0) && active_a;
   end

   assign stat_o.need_step = step;
   assign stat_o.out_free  = !rsp_valid_ff || rsp_tready;

   // Control register writes and the pending flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= GAIN_UNITY;
         fade_ff    <= FADE_RESET;
         chcnt_ff   <= CHCNT_RESET;
         enable_ff  <= ENABLE_RESET;
         pending_ff <= 1'b0;
      end else begin
         if (cmd_i.accept && latch) begin
            pending_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_TARGET_GAIN: begin
                  target_ff  <= csr_wdata[GAIN_W-1:0];
                  pending_ff <= 1'b1;
               end
               CSR_FADE_FRAMES:   fade_ff   <= csr_wdata[FADE_W-1:0];
               CSR_CHANNEL_COUNT: chcnt_ff  <= csr_wdata[CHCNT_W-1:0];
               CSR_ENABLE:        enable_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Ramp state: latched at a block start, stepped once per frame.
   logic signed [GAIN_W:0]  diff;
   logic [DIVIDEND_W-1:0]   step_mag;
   always_comb begin
      diff     = $signed({1'b0, tgt_gain_ff}) - $signed({1'b0, start_gain_ff});
      step_mag = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_gain_ff   <= GAIN_UNITY;
         start_gain_ff <= GAIN_UNITY;
         tgt_gain_ff   <= GAIN_UNITY;
         pos_ff        <= '0;
         len_ff        <= '0;
         idx_ff        <= '0;
      end else begin
         if (cmd_i.accept) begin
            idx_ff <= CH_W'(nidx5);
            if (enable_ff) begin
               pos_ff <= step ? pos_a + 1'b1 : pos_a;
               if (latch) begin
                  start_gain_ff <= cur_gain_ff;
                  tgt_gain_ff   <= target_ff;
                  len_ff        <= fade_ff;
                  if (fade_ff == '0) begin
                     cur_gain_ff <= target_ff;
                  end
               end
            end
         end
         if (cmd_i.apply) begin
            cur_gain_ff <= start_gain_ff + step_mag[GAIN_W-1:0];
         end
      end
   end

   // Interpolation: product, magnitude, restoring division, one bit per cycle.
   logic [FADE_W:0] rem_sh;
   logic [FADE_W:0] len_ext;
   logic            rem_ge;
   always_comb begin
      len_ext = {1'b0, len_ff};
      rem_sh  = {rem_ff[FADE_W-1:0], quo_ff[DIVIDEND_W-1]};
      rem_ge  = (rem_sh >= len_ext);
   end

   always_ff @(posedge clock) begin
      if (cmd_i.mul) begin
         prod_ff <= diff * $signed({1'b0, pos_ff});
      end
      if (cmd_i.abs_load) begin
         neg_ff <= prod_ff[33];
         quo_ff <= prod_ff[33] ? DIVIDEND_W'(-prod_ff) : DIVIDEND_W'(prod_ff);
         rem_ff <= '0;
      end
      if (cmd_i.div) begin
         rem_ff <= rem_ge ? (rem_sh - len_ext) : rem_sh;
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], rem_ge};
      end
   end

   // Sample capture and gain multiply.
   always_ff @(posedge clock) begin
      if (cmd_i.accept) begin
         sample_ff <= $signed(req_tdata[SB-1:0]);
         bypass_ff <= !enable_ff;
      end
      if (cmd_i.scale) begin
         mul_ff <= sample_ff * $signed({1'b0, cur_gain_ff});
      end
   end

   // Round to nearest (ties up) and saturate.
   logic signed [SB+17:0] biased;
   logic signed [Q_W-1:0] q;
   logic signed [SB-1:0]  q_sat;
   always_comb begin
      biased = $signed({mul_ff[SB+16], mul_ff}) + $signed((SB + 18)'(ROUND_BIAS));
      q      = $signed(biased[SB+17:FRAC_BITS]);
      if (q > SAT_HI) begin
         q_sat = SB'(SAT_HI);
      end else if (q < SAT_LO) begin
         q_sat = SB'(SAT_LO);
      end else begin
         q_sat = SB'(q);
      end
   end

   // Output register; the next transaction may enter while this one waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.round) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.round) begin
         out_sample_ff  <= bypass_ff ? sample_ff : q_sat;
         out_ramping_ff <= (len_ff != '0) && (pos_ff < len_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'($unsigned(out_sample_ff));
   assign rsp_tuser  = out_ramping_ff;

   `ASSERT_ALWAYS(a_pos_bound, len_ff == '0 || pos_ff <= len_ff, "ramp position passed ramp length")
   `ASSERT_NEXT(a_rem_bound, cmd_i.div, rem_ff < len_ext, "divider remainder not below divisor")

endmodule

// ===== sv/ramped_gain_stage_top.sv =====
// Ramped gain stage: scales interleaved audio samples by a Q4.12 gain.
// Input stream req_*: one sample per transaction, block_start in req_tuser.
// Output stream rsp_*: one scaled, saturated sample per input transaction
// (raw while disabled), with the ramp-in-progress flag in rsp_tuser.
// Control port csr_*: single-cycle writes of target gain, fade length,
// channel count and enable; write only while no sample is in flight.
// At the first sample of a frame while a ramp runs, the interpolated gain
// goes through a 17x17 multiply and a 32-step restoring divider before
// the sample is scaled. One sample is processed at a time, so the next
// is taken only once this one has reached the output register.
// The result sits in an output register; the next sample is taken while it
// waits. A stalled receiver holds the following sample in the final stage.
// Reset is synchronous: unity gain, no ramp, 2 channels, gain enabled.
module ramped_gain_stage_top #(
   parameter  int SAMPLE_BITS  = 24,
   parameter  int MAX_CHANNELS = 8,
   localparam int DATA_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rgs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rgs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [DATA_W-1:0]              req_tdata,  // sample_in
   input  logic                           req_tuser,  // block_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [DATA_W-1:0]              rsp_tdata,  // sample_out
   output logic                           rsp_tuser   // ramping
);
   import rgs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat_i     (stat),
      .cmd_o      (cmd)
   );

   rgs_datapath #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_i      (cmd),
      .stat_o     (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/rgs_checker.sv =====
`timescale 1ns / 100ps

// Watches the sample streams and the control port of the ramped gain stage,
// computes each scaled sample with its own copy of the gain and ramp state,
// and compares every output transaction with the oldest sample still due.
module rgs_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rgs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rgs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [23:0]                    req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [23:0]                    rsp_tdata,
   input  logic                           rsp_tuser,
   output int                             fail_count,
   output int                             pending_count
);
   import rgs_pkg::*;

   localparam int MAX_CH = 8;
   localparam longint SAT_HI = 64'sd8388607;
   localparam longint SAT_LO = -64'sd8388608;

   typedef struct packed {
      logic [23:0] sample;
      logic        ramping;
   } scaled_sample_type;

   scaled_sample_type scaled_samples_due[$];
   int                error_total = 0;

   // Copy of the control registers.
   logic [GAIN_W-1:0]  target_reg;
   logic [FADE_W-1:0]  fade_reg;
   logic [CHCNT_W-1:0] chans_reg;
   logic               enable_reg;

   // Copy of the gain and ramp state.
   logic [GAIN_W-1:0] gain_now;
   logic [GAIN_W-1:0] ramp_from;
   logic [GAIN_W-1:0] ramp_to;
   logic [FADE_W-1:0] ramp_pos;
   logic [FADE_W-1:0] ramp_len;
   logic              change_pending;
   int                frame_slot;

   function automatic int active_channels(input logic [CHCNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_CH) return MAX_CH;
      return int'(count);
   endfunction

   function automatic logic ramp_running();
      return (ramp_len != 0) && (ramp_pos < ramp_len);
   endfunction

   // Multiply by the Q4.12 gain, round half up, saturate to 24 bits.
   function automatic logic [23:0] apply_gain(input logic signed [23:0] sample,
                                              input logic [GAIN_W-1:0] gain);
      longint product;
      product = longint'(sample) * longint'(gain) + ROUND_BIAS;
      product = product >>> FRAC_BITS;
      if (product > SAT_HI) product = SAT_HI;
      if (product < SAT_LO) product = SAT_LO;
      return product[23:0];
   endfunction

   // Advance the gain state by one accepted sample and queue its result.
   task automatic scale_and_ramp(input logic [23:0] raw, input logic first);
      longint            diff;
      longint            step;
      scaled_sample_type due;
      if (first) frame_slot = 0;
      if (frame_slot >= active_channels(chans_reg)) frame_slot = 0;
      if (enable_reg) begin
         if (first && change_pending) begin
            change_pending = 1'b0;
            ramp_from = gain_now;
            ramp_to = target_reg;
            ramp_len = fade_reg;
            ramp_pos = '0;
            if (ramp_len == 0) gain_now = ramp_to;
         end
         // Gain moves once per frame, on its first channel.
         if (frame_slot == 0 && ramp_running()) begin
            ramp_pos = ramp_pos + 1'b1;
            diff = longint'(ramp_to) - longint'(ramp_from);
            step = diff * longint'(ramp_pos) / longint'(ramp_len);
            gain_now = GAIN_W'(longint'(ramp_from) + step);
         end
         due.sample = apply_gain(raw, gain_now);
      end else begin
         due.sample = raw;
      end
      frame_slot++;
      if (frame_slot >= active_channels(chans_reg)) frame_slot = 0;
      due.ramping = ramp_running();
      scaled_samples_due.push_back(due);
   endtask

   always @(posedge clock) begin
      scaled_sample_type want;
      if (reset) begin
         target_reg = GAIN_UNITY;
         fade_reg = FADE_RESET;
         chans_reg = CHCNT_RESET;
         enable_reg = ENABLE_RESET;
         gain_now = GAIN_UNITY;
         ramp_from = GAIN_UNITY;
         ramp_to = GAIN_UNITY;
         ramp_pos = '0;
         ramp_len = '0;
         change_pending = 1'b0;
         frame_slot = 0;
         scaled_samples_due.delete();
      end else begin
         // Register writes only come while no sample is in flight.
         if (csr_we) begin
            case (csr_addr)
               CSR_TARGET_GAIN: begin
                  target_reg = csr_wdata[GAIN_W-1:0];
                  change_pending = 1'b1;
               end
               CSR_FADE_FRAMES:   fade_reg = csr_wdata[FADE_W-1:0];
               CSR_CHANNEL_COUNT: chans_reg = csr_wdata[CHCNT_W-1:0];
               CSR_ENABLE:        enable_reg = csr_wdata[0];
               default: ;
            endcase
         end

         // Output transaction: compare against the oldest sample due.
         if (rsp_tvalid && rsp_tready) begin
            if (scaled_samples_due.size() == 0) begin
               $display("%0t: output with no sample due, actual sample_out %h ramping %b",
                        $time, rsp_tdata, rsp_tuser);
               error_total++;
            end else begin
               want = scaled_samples_due.pop_front();
               if (rsp_tdata !== want.sample) begin
                  $display("%0t: sample_out mismatch, expected %h, actual %h",
                           $time, want.sample, rsp_tdata);
                  error_total++;
               end
               if (rsp_tuser !== want.ramping) begin
                  $display("%0t: ramping mismatch, expected %b, actual %b",
                           $time, want.ramping, rsp_tuser);
                  error_total++;
               end
            end
         end

         // Input transaction: predict its result.
         if (req_tvalid && req_tready) scale_and_ramp(req_tdata, req_tuser);
      end
      fail_count <= error_total;
      pending_count <= scaled_samples_due.size();
   end

endmodule

// ===== tb/tb_ramped_gain_stage_top.sv =====
`timescale 1ns / 100ps

module tb_ramped_gain_stage_top;
   import rgs_pkg::*;

   localparam int RUN_LIMIT   = 400000;
   localparam int PHASE_ITEMS = 270;
   localparam int MAX_CH      = 8;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tuser;

   int fail_count;
   int pending_count;
   int cycle_count   = 0;
   int samples_sent  = 0;
   int send_idle_pct = 6;
   int recv_idle_pct = 53;
   int frame_width   = 2;

   ramped_gain_stage_top uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample_in
      .req_tuser  (req_tuser),   // block_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // sample_out
      .rsp_tuser  (rsp_tuser)    // ramping
   );

   rgs_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random backpressure at the current idle rate.
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one sample and hold it until the block takes it.
   task automatic put_sample(input logic [23:0] value, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   // Stop sending and wait until every scaled sample has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_CHANNEL_COUNT) begin
         if (value[CHCNT_W-1:0] == 0) frame_width = 1;
         else if (value[CHCNT_W-1:0] > MAX_CH) frame_width = MAX_CH;
         else frame_width = int'(value[CHCNT_W-1:0]);
      end
   endtask

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(32) - 16);
         default: return 24'($urandom());
      endcase
   endfunction

   // One buffer of whole frames, or a broken one with a ragged length and
   // stray block starts.
   task automatic send_buffer(input int frames, input bit broken);
      int length;
      length = frames * frame_width;
      if (broken) length = $urandom_range(1, length + frame_width);
      for (int i = 0; i < length; i++) begin
         put_sample(pick_sample(), (i == 0) || (broken && $urandom_range(9) == 0));
      end
   endtask

   // New settings between idle points, then a few buffers of audio.
   task automatic random_episode();
      int buffers;
      drain();
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(7))
            0: write_reg(CSR_TARGET_GAIN, 16'hFFFF);
            1: write_reg(CSR_TARGET_GAIN, 16'h0000);
            default: write_reg(CSR_TARGET_GAIN, 16'($urandom_range(16384)));
         endcase
      end
      if ($urandom_range(2) == 0) begin
         case ($urandom_range(9))
            0: write_reg(CSR_FADE_FRAMES, 16'hFFFF);
            1, 2: write_reg(CSR_FADE_FRAMES, 16'($urandom_range(9, 40)));
            default: write_reg(CSR_FADE_FRAMES, 16'($urandom_range(8)));
         endcase
      end
      if ($urandom_range(4) == 0) begin
         if ($urandom_range(4) == 0) write_reg(CSR_CHANNEL_COUNT, 16'($urandom_range(15)));
         else write_reg(CSR_CHANNEL_COUNT, 16'($urandom_range(1, MAX_CH)));
      end
      if ($urandom_range(5) == 0) write_reg(CSR_ENABLE, 16'($urandom_range(9) != 0));
      buffers = $urandom_range(1, 3);
      for (int b = 0; b < buffers; b++) begin
         send_buffer($urandom_range(1, 6), $urandom_range(6) == 0);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_addr <= CSR_TARGET_GAIN;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unity gain after reset passes the extremes through.
      put_sample(24'h7FFFFF, 1'b1);
      put_sample(24'h800000, 1'b0);
      put_sample(24'h000000, 1'b0);
      put_sample(24'hFFFFFF, 1'b0);

      // Full-scale gain with no fade: jumps at once and saturates both ways.
      drain();
      write_reg(CSR_FADE_FRAMES, 16'd0);
      write_reg(CSR_TARGET_GAIN, 16'hFFFF);
      put_sample(24'h7FFFFF, 1'b1);
      put_sample(24'h800000, 1'b0);
      put_sample(24'h000001, 1'b0);
      put_sample(24'hFFFFFF, 1'b0);

      // Half gain puts odd samples on rounding ties.
      drain();
      write_reg(CSR_TARGET_GAIN, 16'd2048);
      put_sample(24'h000001, 1'b1);
      put_sample(24'hFFFFFF, 1'b0);
      put_sample(24'h000003, 1'b0);
      put_sample(24'hFFFFFD, 1'b0);

      // Three-frame ramp down to zero gain, one channel per frame.
      drain();
      write_reg(CSR_CHANNEL_COUNT, 16'd1);
      write_reg(CSR_FADE_FRAMES, 16'd3);
      write_reg(CSR_TARGET_GAIN, 16'd0);
      for (int i = 0; i < 4; i++) put_sample(24'h400000, i == 0);

      // Disabled: pass through, the new target stays pending.
      drain();
      write_reg(CSR_ENABLE, 16'd0);
      write_reg(CSR_TARGET_GAIN, 16'd4096);
      put_sample(24'h123456, 1'b1);
      put_sample(24'hFEDCBA, 1'b0);

      // Enabled again with zero channels and the longest fade.
      drain();
      write_reg(CSR_ENABLE, 16'd1);
      write_reg(CSR_CHANNEL_COUNT, 16'd0);
      write_reg(CSR_FADE_FRAMES, 16'hFFFF);
      put_sample(24'h400000, 1'b1);
      put_sample(24'h400000, 1'b0);

      // Oversized channel count, then shrink it below the running index.
      drain();
      write_reg(CSR_CHANNEL_COUNT, 16'd15);
      for (int i = 0; i < 3; i++) put_sample(24'h300000, i == 0);
      drain();
      write_reg(CSR_CHANNEL_COUNT, 16'd1);
      put_sample(24'h300000, 1'b0);

      // Random traffic in three idle regimes.
      drain();
      write_reg(CSR_CHANNEL_COUNT, 16'd8);
      write_reg(CSR_FADE_FRAMES, 16'd4);
      write_reg(CSR_TARGET_GAIN, 16'($urandom_range(16384)));
      for (int phase = 0; phase < 3; phase++) begin
         drain();
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 53;
            end
            1: begin
               send_idle_pct = 53;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (samples_sent < (phase + 1) * PHASE_ITEMS + 24) random_episode();
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
